// File: design/mceo_pkg.sv
// Shared types, constants and opcodes for the column elementary ops unit.
package mceo_pkg;

   localparam int unsigned DIM = 8;
   localparam int unsigned IDX_W = 3;
   localparam int unsigned ADDR_W = 6;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_SWAP = 3'd1,
      OP_SCALE = 3'd2,
      OP_ADD = 3'd3,
      OP_SUB = 3'd4,
      OP_READ = 3'd5,
      OP_IDENT = 3'd6,
      OP_BAD = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_RANGE = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   localparam logic CSR_ORDER = 1'b0;
   localparam logic CSR_TRACK = 1'b1;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] row;
      logic [2:0] target_col;
      logic [2:0] source_col;
      logic signed [15:0] multiplier;
      logic signed [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic signed [31:0] matrix_value;
      logic signed [31:0] elementary_value;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CALC,
      S_WRITE,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic rd;        // read row pair
      logic calc;      // compute row result
      logic wr;        // write row result
      logic next_row;  // advance row counter
      logic rsp_load;  // commit single-word op
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_row;
      logic single;    // op needs no sweep
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) return 32'sh7fff_ffff;
      if (v < -50'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

// File: design/mceo_ctrl.sv
// Controller state machine sequencing the row sweep.
module mceo_ctrl import mceo_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_READ;
         S_READ: state_in = sts.single ? S_RESP : S_CALC;
         S_CALC: state_in = S_WRITE;
         S_WRITE: state_in = sts.last_row ? S_RESP : S_READ;
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         S_READ: begin
            cmd.rd = 1'b1;
            cmd.rsp_load = sts.single;
         end
         S_CALC: cmd.calc = 1'b1;
         S_WRITE: begin
            cmd.wr = 1'b1;
            cmd.next_row = 1'b1;
         end
         S_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   a_one_hs: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("both channels open");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_READ) else $error("no start");

endmodule

// File: design/mceo_dp.sv
// Datapath: matrix and elementary stores, row sweep and saturating multiply-add.
module mceo_dp import mceo_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   input  req_type req,
   input  logic [3:0] order_in_use,
   input  logic track_elementary,
   output sts_type sts,
   output rsp_type rsp
);

   logic [31:0] mat_mem [DIM*DIM];
   logic [31:0] ele_mem [DIM*DIM];

   req_type req_ff;
   logic [IDX_W-1:0] row_ff;
   logic [IDX_W-1:0] last_ff;
   logic [1:0] status_ff;
   logic track_ff;
   // elementary entries that hold identity until first written since identity load
   logic [DIM*DIM-1:0] ele_dirty_ff;
   logic signed [31:0] mt_ff, ms_ff, et_ff, es_ff;
   logic signed [31:0] mt_res_ff, ms_res_ff, et_res_ff, es_res_ff;

   logic [IDX_W-1:0] order_m1;
   logic [IDX_W:0] n;
   logic [2:0] op;
   logic range_bad;
   logic [ADDR_W-1:0] addr_t, addr_s, addr_rw, addr_a;

   always_comb begin
      n = (order_in_use == 4'd0) ? 4'd1 : (order_in_use > 4'd8 ? 4'd8 : order_in_use);
      order_m1 = IDX_W'(n - 4'd1);
      op = req.op;
      unique case (op) inside
         OP_WRITE, OP_READ: range_bad = ({1'b0, req.row} >= n) || ({1'b0, req.target_col} >= n);
         OP_SCALE: range_bad = {1'b0, req.target_col} >= n;
         OP_SWAP, OP_ADD, OP_SUB: range_bad = ({1'b0, req.target_col} >= n)
                                     || ({1'b0, req.source_col} >= n);
         default: range_bad = 1'b0;
      endcase
      addr_t = {row_ff, req_ff.target_col};
      addr_s = {row_ff, req_ff.source_col};
      addr_rw = {req_ff.row, req_ff.target_col};
      // first read port serves the entry read or the target column
      addr_a = (req_ff.op == OP_READ) ? addr_rw : addr_t;
   end

   function automatic logic [31:0] ident_val(input logic [ADDR_W-1:0] a);
      return (a[5:3] == a[2:0]) ? Q_ONE : 32'd0;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         row_ff <= '0;
         last_ff <= order_m1;
         track_ff <= track_elementary;
         if (req.op == OP_BAD) status_ff <= ST_INVALID;
         else if (range_bad) status_ff <= ST_RANGE;
         else status_ff <= ST_DONE;
      end else if (cmd.next_row) begin
         row_ff <= row_ff + 1'b1;
      end
   end

   logic active;
   assign active = status_ff == ST_DONE;
   // identity reload is done at capture by clearing the written flags
   assign sts.single = !active || req_ff.op == OP_WRITE || req_ff.op == OP_READ
                       || req_ff.op == OP_IDENT;
   assign sts.last_row = row_ff == last_ff;

   // reads: two addresses per store, registered
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         mt_ff <= mat_mem[addr_a];
         ms_ff <= mat_mem[addr_s];
         et_ff <= ele_dirty_ff[addr_a] ? ele_mem[addr_a] : ident_val(addr_a);
         es_ff <= ele_dirty_ff[addr_s] ? ele_mem[addr_s] : ident_val(addr_s);
      end
   end

   // one multiplier per store per row
   logic signed [15:0] k;
   assign k = req_ff.multiplier;

   logic signed [47:0] mprod, eprod;
   assign mprod = (req_ff.op == OP_SCALE ? mt_ff : ms_ff) * k;
   assign eprod = (req_ff.op == OP_SCALE ? et_ff : es_ff) * k;

   function automatic logic signed [31:0] combine(input logic [2:0] o,
         input logic signed [31:0] a, input logic signed [47:0] p);
      logic signed [49:0] wa, wp;
      wa = 50'(a);
      wp = 50'(p);
      unique case (o)
         OP_SCALE: return sat32(wp);
         OP_ADD: return sat32(wa + wp);
         default: return sat32(wa - wp);
      endcase
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         if (req_ff.op == OP_SWAP) begin
            mt_res_ff <= ms_ff; ms_res_ff <= mt_ff;
            et_res_ff <= es_ff; es_res_ff <= et_ff;
         end else begin
            mt_res_ff <= combine(req_ff.op, mt_ff, mprod);
            et_res_ff <= combine(req_ff.op, et_ff, eprod);
            ms_res_ff <= ms_ff; es_res_ff <= es_ff;
         end
      end
   end

   logic wr_src;
   assign wr_src = req_ff.op == OP_SWAP && req_ff.source_col != req_ff.target_col;

   // second column of a swap goes through the second write port
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mat_mem[addr_t] <= mt_res_ff;
         if (track_ff) ele_mem[addr_t] <= et_res_ff;
         if (wr_src) begin
            mat_mem[addr_s] <= ms_res_ff;
            if (track_ff) ele_mem[addr_s] <= es_res_ff;
         end
      end else if (cmd.rsp_load && active && req_ff.op == OP_WRITE) begin
         mat_mem[addr_rw] <= req_ff.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.load && req.op == OP_IDENT)) ele_dirty_ff <= '0;
      else if (cmd.wr && track_ff) begin
         ele_dirty_ff[addr_t] <= 1'b1;
         if (wr_src) ele_dirty_ff[addr_s] <= 1'b1;
      end
   end

   // response built from registers only; stable while the controller waits
   always_comb begin
      rsp.status = status_ff;
      rsp.matrix_value = (active && req_ff.op == OP_READ) ? mt_ff : '0;
      rsp.elementary_value = (active && req_ff.op == OP_READ) ? et_ff : '0;
   end

endmodule

// File: design/matrix_column_elementary_ops_unit.sv
// Top level of the matrix column elementary operations unit.
//  channel | dir | payload   | handshake
//  req_    | in  | req_type  | req_valid / req_ready
//  rsp_    | out | rsp_type  | rsp_valid / rsp_ready
//  csr_    | in  | idx, data | csr_valid / csr_ready
// Write, read, identity, invalid and out-of-range words pass from accept to
// next accept through the idle, read and response states. Column ops sweep
// the rows: each row is read, combined through one 32x16 multiplier per store,
// then written back. Identity reload clears per-entry written flags at accept.
// Reset is synchronous; it clears control state and the elementary flags.
// A stalled result holds the unit; the next word is taken after delivery.
module matrix_column_elementary_ops_unit import mceo_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [3:0] csr_data
);

   logic [3:0] order_ff;
   logic track_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 4'd8;
         track_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ORDER: order_ff <= csr_data;
            CSR_TRACK: track_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   mceo_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   mceo_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data),
      .order_in_use(order_ff), .track_elementary(track_ff),
      .sts(sts), .rsp(rsp_data)
   );

endmodule
